// ===== hw/rtl/slht_pkg.sv =====
// Shared constants, control structs and the arctangent table of the heading tracker.
package slht_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 12;

    localparam int CENTER_W   = 11;
    localparam int RATE_W     = 16;
    localparam int MS_W       = 10;
    localparam int LIMIT_W    = RATE_W + MS_W;
    localparam int RATE_FRAC  = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int ACC_W        = 32;
    localparam int FRAC_BITS    = 20;
    localparam int GUARD_BITS   = 3;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE = 2'd2;

    localparam logic [CENTER_W-1:0] CENTER_X_RST  = 11'd400;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST  = 11'd300;
    localparam logic [RATE_W-1:0]   TURN_RATE_RST = 16'd4194;

    typedef struct packed {
        logic              load;
        logic              iterate;
        logic [STEP_W-1:0] step;
    } cordic_ctl_t;

    typedef struct packed {
        logic diff_en;
        logic clamp_en;
    } slew_ctl_t;

    // atan(2^-i) as a 32-bit fraction of a turn
    function automatic logic [ACC_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [ACC_W-1:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/slht_if.sv =====
// Valid/ready channel interfaces for input and result words.
interface slht_in_if #(
    parameter int COORD_BITS = slht_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic [slht_pkg::MS_W-1:0]    elapsed_ms;

    modport source (output valid, target_x, target_y, elapsed_ms, input ready);
    modport sink   (input valid, target_x, target_y, elapsed_ms, output ready);
endinterface

interface slht_out_if #(
    parameter int ANGLE_BITS = slht_pkg::ANGLE_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic [ANGLE_BITS-1:0]      new_heading;
    logic signed [ANGLE_BITS:0] applied_turn;

    modport source (output valid, new_heading, applied_turn, input ready);
    modport sink   (input valid, new_heading, applied_turn, output ready);
endinterface

// ===== hw/rtl/slew_limited_heading_tracker_core.sv =====
// Top level of the slew-limited heading tracker: sequencer, config and output register.
//
//  channel   dir  handshake        word contents
//  in_ch     in   valid/ready      target_x, target_y, elapsed_ms
//  out_ch    out  valid/ready      new_heading, applied_turn
//  cfg       in   cfg_we only      cfg_index, cfg_data (center_x, center_y, turn_rate)
//
// Each word passes through accept, vector load, 24 iterations of the shared CORDIC
// shift-add unit, round, difference, clamp and output before in_ch is ready again.
// rst_n clears the heading, the config registers to their defaults and the sequencer.
// A finished word waits in the output register; the sequencer holds in its output
// step only when a second result arrives before the first one is taken.
module slew_limited_heading_tracker_core #(
    parameter int ANGLE_BITS = slht_pkg::ANGLE_BITS_DEF,
    parameter int COORD_BITS = slht_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    slht_in_if.sink                        in_ch,
    slht_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [slht_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slht_pkg::CFG_W-1:0]     cfg_data
);
    localparam int SH = slht_pkg::ACC_W - ANGLE_BITS;
    localparam logic [slht_pkg::STEP_W-1:0] LAST_STEP = slht_pkg::STEP_W'(slht_pkg::CORDIC_STEPS - 1);
    localparam logic [slht_pkg::ACC_W:0] ROUND_HALF = (slht_pkg::ACC_W + 1)'(1) << (SH - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_ITER  = 7'b0000100,
        S_ROUND = 7'b0001000,
        S_DIFF  = 7'b0010000,
        S_CLAMP = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [slht_pkg::STEP_W-1:0] step_reg, step_next;

    // config registers
    logic [slht_pkg::CENTER_W-1:0] cx_reg, cy_reg;
    logic [slht_pkg::RATE_W-1:0]   rate_reg;

    // captured input word
    logic signed [COORD_BITS-1:0] tx_reg, ty_reg;
    logic [slht_pkg::MS_W-1:0]    ms_reg;

    logic [ANGLE_BITS-1:0]        heading_reg;
    logic [ANGLE_BITS-1:0]        bearing_reg;
    logic [slht_pkg::LIMIT_W-1:0] limit_reg;

    // output register
    logic                       out_v_reg;
    logic [ANGLE_BITS-1:0]      nh_reg;
    logic signed [ANGLE_BITS:0] at_reg;

    slht_pkg::cordic_ctl_t      cordic_ctl;
    slht_pkg::slew_ctl_t        slew_ctl;
    logic [slht_pkg::ACC_W-1:0] acc;
    logic                       is_zero;
    logic signed [ANGLE_BITS:0] turn;
    logic [slht_pkg::ACC_W:0]   rsum;
    logic                       in_acc, out_free;
    logic [ANGLE_BITS-1:0]      heading_new;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_v_reg || out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_ITER;
                step_next  = '0;
            end
            S_ITER:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_ROUND: state_next = S_DIFF;
            S_DIFF:  state_next = S_CLAMP;
            S_CLAMP: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cordic_ctl.load     = (state_reg == S_LOAD);
        cordic_ctl.iterate  = (state_reg == S_ITER);
        cordic_ctl.step     = step_reg;
        slew_ctl.diff_en    = (state_reg == S_DIFF);
        slew_ctl.clamp_en   = (state_reg == S_CLAMP);
        // round half up to the angle width; the carry out wraps away
        rsum        = {1'b0, acc} + ROUND_HALF;
        heading_new = heading_reg + turn[ANGLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            heading_reg <= '0;
            out_v_reg   <= 1'b0;
            cx_reg      <= slht_pkg::CENTER_X_RST;
            cy_reg      <= slht_pkg::CENTER_Y_RST;
            rate_reg    <= slht_pkg::TURN_RATE_RST;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    slht_pkg::REG_CENTER_X:  cx_reg   <= cfg_data[slht_pkg::CENTER_W-1:0];
                    slht_pkg::REG_CENTER_Y:  cy_reg   <= cfg_data[slht_pkg::CENTER_W-1:0];
                    slht_pkg::REG_TURN_RATE: rate_reg <= cfg_data[slht_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_OUT && out_free)
            begin
                heading_reg <= heading_new;
                out_v_reg   <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            tx_reg <= in_ch.target_x;
            ty_reg <= in_ch.target_y;
            ms_reg <= in_ch.elapsed_ms;
        end
        if (state_reg == S_ROUND)
        begin
            bearing_reg <= is_zero ? '0 : rsum[slht_pkg::ACC_W-1:SH];
            limit_reg   <= rate_reg * ms_reg;
        end
        if (state_reg == S_OUT && out_free)
        begin
            nh_reg <= heading_new;
            at_reg <= turn;
        end
    end

    slht_cordic #(
        .COORD_BITS(COORD_BITS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cordic_ctl),
        .center_x(cx_reg),
        .center_y(cy_reg),
        .target_x(tx_reg),
        .target_y(ty_reg),
        .acc     (acc),
        .is_zero (is_zero)
    );

    slht_slew #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_slew (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (slew_ctl),
        .bearing(bearing_reg),
        .heading(heading_reg),
        .limit  (limit_reg),
        .turn   (turn)
    );

    assign out_ch.valid        = out_v_reg;
    assign out_ch.new_heading  = nh_reg;
    assign out_ch.applied_turn = at_reg;

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_LOAD))
        else $error("accept did not start vector load");

    a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_OUT) |=> $stable(heading_reg))
        else $error("heading moved outside output step");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result valid without output step");

    a_result_heading: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (nh_reg == heading_reg))
        else $error("output heading differs from stored heading");
endmodule

// ===== hw/rtl/slht_cordic.sv =====
// Vectoring CORDIC datapath: one shift-add iteration per cycle on shared registers.
module slht_cordic #(
    parameter int COORD_BITS = slht_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slht_pkg::cordic_ctl_t         ctl,
    input  logic [slht_pkg::CENTER_W-1:0] center_x,
    input  logic [slht_pkg::CENTER_W-1:0] center_y,
    input  logic signed [COORD_BITS-1:0]  target_x,
    input  logic signed [COORD_BITS-1:0]  target_y,
    output logic [slht_pkg::ACC_W-1:0]    acc,
    output logic                          is_zero
);
    localparam int CS_W = slht_pkg::CENTER_W + 1;
    localparam int DX_W = ((COORD_BITS > CS_W) ? COORD_BITS : CS_W) + 1;
    localparam int W    = DX_W + slht_pkg::FRAC_BITS + slht_pkg::GUARD_BITS;
    localparam logic [slht_pkg::ACC_W-1:0] HALF_TURN = {1'b1, {(slht_pkg::ACC_W-1){1'b0}}};

    logic signed [W-1:0]          x_reg, y_reg;
    logic [slht_pkg::ACC_W-1:0]   acc_reg;
    logic                         zero_reg;

    logic signed [DX_W-1:0] dx, dy, dxn, dyn;
    logic                   flip;
    logic signed [W-1:0]    x_load, y_load, xs, ys;
    logic [slht_pkg::ACC_W-1:0] atan_v;

    always_comb
    begin
        dx     = DX_W'(target_x) - $signed(DX_W'(center_x));
        dy     = DX_W'(target_y) - $signed(DX_W'(center_y));
        flip   = dx[DX_W-1];
        // left half plane: pre-rotate by half a turn
        dxn    = flip ? -dx : dx;
        dyn    = flip ? -dy : dy;
        x_load = W'(dxn) <<< slht_pkg::FRAC_BITS;
        y_load = W'(dyn) <<< slht_pkg::FRAC_BITS;
        xs     = x_reg >>> ctl.step;
        ys     = y_reg >>> ctl.step;
        atan_v = slht_pkg::atan_turn(ctl.step);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg    <= x_load;
            y_reg    <= y_load;
            acc_reg  <= flip ? HALF_TURN : '0;
            zero_reg <= (dx == '0) && (dy == '0);
        end
        else if (ctl.iterate)
        begin
            if (!y_reg[W-1])
            begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                acc_reg <= acc_reg + atan_v;
            end
            else
            begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                acc_reg <= acc_reg - atan_v;
            end
        end
    end

    assign acc     = acc_reg;
    assign is_zero = zero_reg;

    // step index must stay inside the table while iterating
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.iterate |-> (int'(ctl.step) < slht_pkg::CORDIC_STEPS))
        else $error("cordic step out of range");

    a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load && ctl.iterate))
        else $error("cordic load and iterate together");

    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && dx == '0 && dy == '0) |=> is_zero)
        else $error("zero vector not flagged");
endmodule

// ===== hw/rtl/slht_slew.sv =====
// Shortest signed turn from heading to bearing, clamped to the slew limit.
module slht_slew #(
    parameter int ANGLE_BITS = slht_pkg::ANGLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  slht_pkg::slew_ctl_t          ctl,
    input  logic [ANGLE_BITS-1:0]        bearing,
    input  logic [ANGLE_BITS-1:0]        heading,
    input  logic [slht_pkg::LIMIT_W-1:0] limit,
    output logic signed [ANGLE_BITS:0]   turn
);
    localparam int MW = ANGLE_BITS + slht_pkg::RATE_FRAC;
    localparam int CW = (MW > slht_pkg::LIMIT_W) ? MW : slht_pkg::LIMIT_W;
    localparam logic [ANGLE_BITS-1:0] HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    logic [ANGLE_BITS-1:0]      mag_reg;
    logic                       neg_reg;
    logic signed [ANGLE_BITS:0] turn_reg;

    logic [ANGLE_BITS-1:0] diffu, mag_c;
    logic                  gt;
    logic [CW-1:0]         mag_w, lim_w, cut_w;
    logic                  over;

    always_comb
    begin
        diffu = bearing - heading;
        gt    = diffu > HALF;   // exact half turn stays positive
        mag_w = CW'({mag_reg, {slht_pkg::RATE_FRAC{1'b0}}});
        lim_w = CW'(limit);
        cut_w = lim_w >> slht_pkg::RATE_FRAC;
        over  = mag_w > lim_w;
        mag_c = over ? cut_w[ANGLE_BITS-1:0] : mag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.diff_en)
        begin
            mag_reg <= gt ? -diffu : diffu;
            neg_reg <= gt;
        end
        if (ctl.clamp_en)
        begin
            turn_reg <= neg_reg ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
        end
    end

    assign turn = turn_reg;

    a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clamp_en |-> (CW'({mag_c, {slht_pkg::RATE_FRAC{1'b0}}}) <= lim_w))
        else $error("clamped turn exceeds limit");

    a_steps_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.diff_en && ctl.clamp_en))
        else $error("diff and clamp in same cycle");

    a_mag_half: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.diff_en |=> (mag_reg <= HALF))
        else $error("turn magnitude above half turn");
endmodule
